/* src/rmpa_pkg.sv */
// shared widths, constants and divider handshake types for the priority assignment block
`timescale 1ns / 1ps

package rmpa_pkg;

  // fixed field widths
  localparam int PERIOD_W = 16;
  localparam int COMP_W   = 16;
  localparam int UTIL_W   = 20;
  localparam int IDX_W    = 3;
  localparam int PRIO_W   = 4;

  // saturated utilization value
  localparam logic [UTIL_W-1:0] UTIL_MAX = '1;

  // default bound is 0.7 in fixed point
  localparam int BOUND_NUM = 7;
  localparam int BOUND_DEN = 10;

  // divider request
  typedef struct packed {
    logic                start;
    logic [COMP_W-1:0]   comp;
    logic [PERIOD_W-1:0] per;
  } div_req_t;

  // divider response
  typedef struct packed {
    logic              done;
    logic [UTIL_W-1:0] quot;
  } div_rsp_t;

endpackage

/* src/rmpa_if.sv */
// valid/ready channel interfaces for task, result and bound beats
`timescale 1ns / 1ps

interface rmpa_task_if import rmpa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [PERIOD_W-1:0] period;
  logic [COMP_W-1:0]   compute_time;
  logic                last;

  modport source (output valid, output period, output compute_time, output last,
                  input ready);
  modport sink (input valid, input period, input compute_time, input last,
                output ready);
endinterface

interface rmpa_res_if import rmpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  task_index;
  logic [PRIO_W-1:0] priority_res;
  logic              schedulable;
  logic [UTIL_W-1:0] utilization;
  logic              last_result;

  modport source (output valid, output task_index, output priority_res,
                  output schedulable, output utilization, output last_result,
                  input ready);
  modport sink (input valid, input task_index, input priority_res,
                input schedulable, input utilization, input last_result,
                output ready);
endinterface

interface rmpa_cfg_if import rmpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [UTIL_W-1:0] utilization_bound;

  modport source (output valid, output utilization_bound, input ready);
  modport sink (input valid, input utilization_bound, output ready);
endinterface

/* src/rmpa_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps

module rmpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* src/rmpa_div.sv */
// restoring divider for the saturated fixed-point task load
`timescale 1ns / 1ps

module rmpa_div import rmpa_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int DW = COMP_W + FRAC_BITS;
  localparam int CW = $clog2(DW + 1);

  logic                busy;
  logic                done;
  logic [CW-1:0]       cnt;
  logic [DW-1:0]       dvd;
  logic [PERIOD_W-1:0] dsr;
  logic [PERIOD_W-1:0] rem;
  logic [UTIL_W-1:0]   quot;
  logic                ovf;

  logic [PERIOD_W:0]   rem_sh;
  logic [PERIOD_W:0]   diff;
  logic                ge;

  // one quotient bit per cycle
  always_comb begin
    rem_sh = {rem, dvd[DW-1]};
    diff   = rem_sh - {1'b0, dsr};
    ge     = rem_sh >= {1'b0, dsr};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CW'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // datapath, bits shifted past the result width mark saturation
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd  <= {req.comp, {FRAC_BITS{1'b0}}};
      dsr  <= req.per;
      rem  <= '0;
      quot <= '0;
      ovf  <= 1'b0;
    end else if (busy) begin
      dvd  <= {dvd[DW-2:0], 1'b0};
      rem  <= ge ? diff[PERIOD_W-1:0] : rem_sh[PERIOD_W-1:0];
      quot <= {quot[UTIL_W-2:0], ge};
      ovf  <= ovf | quot[UTIL_W-1];
    end
  end

  assign rsp.done = done;
  assign rsp.quot = ovf ? UTIL_MAX : quot;

endmodule

/* src/rate_monotonic_priority_assign.sv */
// top level: task set loading, utilization sum and dense rate-monotonic ranking
// load beat: the divider runs beside the duplicate sweep, and the beat ends when both are done
// a task past MAX_TASKS is dropped without a load; one task beat is taken at a time
// results: each result reads its own period, then sweeps with one ram read per stored period
// a new task beat is taken while the final result still waits in the output register
// reset: sum and count cleared, bound set to 0.7 in fixed point, period store left unwritten
`timescale 1ns / 1ps

module rate_monotonic_priority_assign import rmpa_pkg::*; #(
  parameter int MAX_TASKS = 8,
  parameter int FRAC_BITS = 16
) (
  input logic       clk,
  input logic       rst,
  rmpa_task_if.sink tasks,
  rmpa_res_if.source results,
  rmpa_cfg_if.sink  cfg
);

  localparam int AW    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam logic [UTIL_W-1:0] BOUND_RESET =
    UTIL_W'((64'(BOUND_NUM) << FRAC_BITS) / BOUND_DEN);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOAD  = 6'b000010,
    S_OREAD = 6'b000100,
    S_OCAP  = 6'b001000,
    S_SCAN  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t              state;
  logic [UTIL_W-1:0]   bound;
  logic [UTIL_W-1:0]   sum;
  logic [CNT_W-1:0]    count;
  logic [MAX_TASKS-1:0] first_flags;
  logic [PERIOD_W-1:0] cur_per;
  logic                cur_last;
  logic                dup;
  logic [CNT_W-1:0]    j;
  logic [AW-1:0]       jp;
  logic                rd_valid;
  logic [UTIL_W-1:0]   quot_hold;
  logic                qdone;
  logic                sched;
  logic [CNT_W-1:0]    i;
  logic [IDX_W-1:0]    oidx;
  logic [PERIOD_W-1:0] p_i;
  logic [PRIO_W-1:0]   rank;

  logic                res_valid;
  logic [IDX_W-1:0]    res_index;
  logic [PRIO_W-1:0]   res_prio;
  logic                res_sched;
  logic [UTIL_W-1:0]   res_util;
  logic                res_last;

  logic [UTIL_W:0]     sum_wide;
  logic [UTIL_W-1:0]   sum_next;
  logic                take_task;
  logic                count_full;
  logic                load_fin;
  logic                out_free;
  logic                final_res;

  div_req_t            div_req;
  div_rsp_t            div_rsp;

  logic                ram_we;
  logic [AW-1:0]       ram_raddr;
  logic [PERIOD_W-1:0] ram_rdata;

  // handshakes and shared decode
  assign tasks.ready = (state == S_IDLE);
  assign cfg.ready   = 1'b1;
  assign take_task   = tasks.valid && tasks.ready;
  assign count_full  = (count == CNT_W'(MAX_TASKS));
  assign load_fin    = (j == count) && !rd_valid && qdone;
  assign out_free    = !res_valid || results.ready;
  assign final_res   = (i + CNT_W'(1)) == count;

  // saturating utilization sum
  always_comb begin
    sum_wide = {1'b0, sum} + {1'b0, quot_hold};
    sum_next = sum_wide[UTIL_W] ? UTIL_MAX : sum_wide[UTIL_W-1:0];
  end

  // divider start on a stored task beat
  always_comb begin
    div_req.start = take_task && !count_full;
    div_req.comp  = tasks.compute_time;
    div_req.per   = tasks.period;
  end

  rmpa_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // period store write enable and read address
  always_comb begin
    ram_we    = (state == S_LOAD) && load_fin;
    ram_raddr = (state == S_OREAD) ? i[AW-1:0] : j[AW-1:0];
  end

  rmpa_ram #(
    .WIDTH (PERIOD_W),
    .DEPTH (MAX_TASKS)
  ) u_period_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata (cur_per),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // bound register
  always_ff @(posedge clk) begin
    if (rst) begin
      bound <= BOUND_RESET;
    end else if (cfg.valid && cfg.ready) begin
      bound <= cfg.utilization_bound;
    end
  end

  // sequencer: load, duplicate sweep, per-result rank sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      sum      <= '0;
      count    <= '0;
      qdone    <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      if (div_rsp.done) begin
        quot_hold <= div_rsp.quot;
        qdone     <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (take_task) begin
            cur_per  <= tasks.period;
            cur_last <= tasks.last;
            if (count_full) begin
              // extra task dropped, a last flag still ends the set
              if (tasks.last) begin
                sched <= sum < bound;
                i     <= '0;
                oidx  <= '0;
                state <= S_OREAD;
              end
            end else begin
              j        <= '0;
              dup      <= 1'b0;
              rd_valid <= 1'b0;
              qdone    <= 1'b0;
              state    <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          // look for an earlier equal period while the divider runs
          rd_valid <= (j < count);
          if (j < count) begin
            j <= j + CNT_W'(1);
          end
          if (rd_valid && (ram_rdata == cur_per)) begin
            dup <= 1'b1;
          end
          if (load_fin) begin
            first_flags[count[AW-1:0]] <= !dup;
            sum   <= sum_next;
            count <= count + CNT_W'(1);
            if (cur_last) begin
              sched <= sum_next < bound;
              i     <= '0;
              oidx  <= '0;
              state <= S_OREAD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_OREAD: begin
          state <= S_OCAP;
        end
        S_OCAP: begin
          p_i      <= ram_rdata;
          rank     <= PRIO_W'(1);
          j        <= '0;
          rd_valid <= 1'b0;
          state    <= S_SCAN;
        end
        S_SCAN: begin
          // count distinct longer periods, first occurrence only
          rd_valid <= (j < count);
          jp       <= j[AW-1:0];
          if (j < count) begin
            j <= j + CNT_W'(1);
          end
          if (rd_valid && (ram_rdata > p_i) && first_flags[jp]) begin
            rank <= rank + PRIO_W'(1);
          end
          if ((j == count) && !rd_valid) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            if (final_res) begin
              sum   <= '0;
              count <= '0;
              state <= S_IDLE;
            end else begin
              i     <= i + CNT_W'(1);
              oidx  <= oidx + IDX_W'(1);
              state <= S_OREAD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if ((state == S_EMIT) && out_free) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if ((state == S_EMIT) && out_free) begin
      res_index <= oidx;
      res_prio  <= sched ? rank : '0;
      res_sched <= sched;
      res_util  <= sum;
      res_last  <= final_res;
    end
  end

  assign results.valid        = res_valid;
  assign results.task_index   = res_index;
  assign results.priority_res = res_prio;
  assign results.schedulable  = res_sched;
  assign results.utilization  = res_util;
  assign results.last_result  = res_last;

endmodule
